// ===== sv/hw2d_pkg.sv =====
// Package for the multi-level 2D Haar block: payload structs, command and status types.
// Depends on nothing; used by every module in sv/.
package hw2d_pkg;
  localparam int COEF_W = 25;
  localparam int CFG_W = 7;

  typedef enum logic [0:0] {
    CFG_HEIGHT = 1'b0,
    CFG_WIDTH  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic                     last_coefficient;
    logic                     read_error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic wr_frame;     // write pixel at load address
    logic pass_start;   // begin one 1D pass
    logic pass_col;     // 0 row pass, 1 column pass
    logic rd_frame;     // readout read flag; the controller never sets it and the datapath ignores it
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pass_done;
  } dp_stat_t;
endpackage

// ===== sv/hw2d_datapath.sv =====
// Datapath: frame and scratch memories, Haar pass engine and readout port.
// Depends on hw2d_pkg.
module hw2d_datapath #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH = 64,
  parameter int AW = 12,
  parameter int DW = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hw2d_pkg::dp_cmd_t                 cmd,
  output hw2d_pkg::dp_stat_t                stat,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [hw2d_pkg::COEF_W-1:0] wr_data,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [hw2d_pkg::COEF_W-1:0] rd_data,
  input  logic [DW-1:0]                     w_eff,
  input  logic [DW-1:0]                     rh,
  input  logic [DW-1:0]                     rw
);
  import hw2d_pkg::*;

  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;

  typedef enum logic [4:0] {
    P_IDLE = 5'b00001,
    P_RDA  = 5'b00010,
    P_RDB  = 5'b00100,
    P_WLO  = 5'b01000,
    P_WHI  = 5'b10000
  } pass_state_t;

  logic signed [COEF_W-1:0] frame_mem [DEPTH];
  logic signed [COEF_W-1:0] scratch_mem [DEPTH];

  pass_state_t pstate;
  logic [DW-1:0] line;      // current row or column
  logic [DW-1:0] pos;       // pair index
  logic [DW-1:0] n;         // elements in this line
  logic [DW-1:0] lines;     // lines in this pass
  logic [DW-1:0] half;
  logic [DW-1:0] hi_base;
  logic          col;
  logic signed [COEF_W-1:0] a;
  logic signed [COEF_W-1:0] src_q;
  logic signed [COEF_W:0] sum;
  logic signed [COEF_W:0] dif;
  logic [AW-1:0] src_addr;
  logic [AW-1:0] dst_addr;
  logic [DW-1:0] src_pos;
  logic [DW-1:0] dst_pos;
  logic          odd_tail;
  logic signed [COEF_W-1:0] dst_data;
  logic          dst_we;
  logic [AW-1:0] line_base;
  logic [2*DW+AW-1:0] mul_tmp;

  assign half = n >> 1;
  assign hi_base = half + {{(DW-1){1'b0}}, n[0]};
  assign odd_tail = n[0] && (pos == half);

  // element position to address: row pass strides 1, column pass strides w
  always_comb begin
    mul_tmp = '0;
    if (col) begin
      mul_tmp = (2*DW+AW)'(src_pos) * (2*DW+AW)'(w_eff) + (2*DW+AW)'(line);
      src_addr = mul_tmp[AW-1:0];
    end else begin
      mul_tmp = (2*DW+AW)'(line) * (2*DW+AW)'(w_eff) + (2*DW+AW)'(src_pos);
      src_addr = mul_tmp[AW-1:0];
    end
  end

  always_comb begin
    line_base = col ? AW'(line) : AW'(line) * AW'(w_eff);
    dst_addr = col ? line_base + AW'(dst_pos) * AW'(w_eff) : line_base + AW'(dst_pos);
  end

  always_comb begin
    src_pos = '0;
    unique case (pstate)
      P_RDA:   src_pos = odd_tail ? n - 1'b1 : {pos[DW-2:0], 1'b0};
      P_RDB:   src_pos = {pos[DW-2:0], 1'b1};
      default: src_pos = '0;
    endcase
  end

  assign sum = (COEF_W+1)'(a) + (COEF_W+1)'(src_q);
  assign dif = (COEF_W+1)'(a) - (COEF_W+1)'(src_q);

  always_comb begin
    dst_we = 1'b0;
    dst_pos = pos;
    dst_data = src_q;
    unique case (pstate)
      P_RDB: begin
        dst_we = odd_tail;
        dst_pos = half;
        dst_data = src_q;
      end
      P_WLO: begin
        dst_we = 1'b1;
        dst_pos = pos;
        dst_data = sum[COEF_W:1];
      end
      P_WHI: begin
        dst_we = 1'b1;
        dst_pos = hi_base + pos;
        dst_data = dif[COEF_W:1];
      end
      default: dst_we = 1'b0;
    endcase
  end

  // memory reads, registered; hold the pass operand through both writes of a pair
  always_ff @(posedge clk) begin
    if (pstate == P_RDA || pstate == P_RDB) begin
      if (col) src_q <= scratch_mem[src_addr];
      else     src_q <= frame_mem[src_addr];
    end
    rd_data <= frame_mem[rd_addr];
  end

  // frame memory: pixel loads and column pass results
  always_ff @(posedge clk) begin
    if (cmd.wr_frame) frame_mem[wr_addr] <= wr_data;
    else if (dst_we && col) frame_mem[dst_addr] <= dst_data;
  end

  always_ff @(posedge clk) begin
    if (dst_we && !col) scratch_mem[dst_addr] <= dst_data;
  end

  // pass sequencer: per pair RDA issues a, RDB issues b, WLO, WHI
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= P_IDLE;
      stat.pass_done <= 1'b0;
    end else begin
      stat.pass_done <= 1'b0;
      unique case (pstate)
        P_IDLE: begin
          if (cmd.pass_start) begin
            col <= cmd.pass_col;
            n <= cmd.pass_col ? rh : rw;
            lines <= cmd.pass_col ? rw : rh;
            line <= '0;
            pos <= '0;
            pstate <= P_RDA;
          end
        end
        P_RDA: pstate <= P_RDB;
        P_RDB: begin
          a <= src_q;
          if (odd_tail) begin
            pos <= '0;
            if (line == lines - 1'b1) begin
              pstate <= P_IDLE;
              stat.pass_done <= 1'b1;
            end else begin
              line <= line + 1'b1;
              pstate <= P_RDA;
            end
          end else begin
            pstate <= P_WLO;
          end
        end
        P_WLO: pstate <= P_WHI;
        P_WHI: begin
          if (pos + 1'b1 < hi_base) begin
            pos <= pos + 1'b1;
            pstate <= P_RDA;
          end else begin
            pos <= '0;
            if (line == lines - 1'b1) begin
              pstate <= P_IDLE;
              stat.pass_done <= 1'b1;
            end else begin
              line <= line + 1'b1;
              pstate <= P_RDA;
            end
          end
        end
        default: pstate <= P_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_from_pass: assert property (@(posedge clk) disable iff (rst)
    stat.pass_done |-> $past(pstate) != P_IDLE)
    else $error("pass done without an active pass");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.pass_start && pstate == P_IDLE) |=> pstate == P_RDA)
    else $error("pass did not start");
  a_no_dual_frame_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_frame |-> pstate == P_IDLE)
    else $error("pixel load during a pass");
`endif
endmodule

// ===== sv/hw2d_ctrl.sv =====
// Controller: load and readout indexes, level sequencing, handshakes.
// Depends on hw2d_pkg.
module hw2d_ctrl #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH = 64,
  parameter int FRAC_BITS = 16,
  parameter int AW = 12,
  parameter int DW = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hw2d_pkg::CFG_W-1:0]        cfg_index,
  input  logic [hw2d_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  hw2d_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output hw2d_pkg::out_item_t               out_data,
  output hw2d_pkg::dp_cmd_t                 cmd,
  input  hw2d_pkg::dp_stat_t                stat,
  output logic [AW-1:0]                     wr_addr,
  output logic signed [hw2d_pkg::COEF_W-1:0] wr_data,
  output logic [AW-1:0]                     rd_addr,
  input  logic signed [hw2d_pkg::COEF_W-1:0] rd_data,
  output logic [DW-1:0]                     w_eff,
  output logic [DW-1:0]                     rh,
  output logic [DW-1:0]                     rw
);
  import hw2d_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROWS = 6'b000010,
    S_COLS = 6'b000100,
    S_WAIT = 6'b001000,
    S_READ = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam int COEF_MAX = (1 << (COEF_W-1)) - 1;

  state_t state;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] image_width;
  logic [DW-1:0] h_eff;
  logic [AW:0] total;
  logic [AW:0] load_index;
  logic [AW:0] read_index;
  logic frame_ready;
  logic read_last;
  logic in_xfer;
  logic [COEF_W+8:0] pix_wide;
  logic pass_col;
  logic busy_out;
  logic out_load;

  function automatic logic [DW-1:0] eff(input logic [CFG_W-1:0] r, input int unsigned mx);
    logic [DW-1:0] res;
    if (r == '0) res = DW'(1);
    else if (32'(r) > mx) res = DW'(mx);
    else res = DW'(r);
    return res;
  endfunction

  assign h_eff = eff(image_height, MAX_HEIGHT);
  assign w_eff = eff(image_width, MAX_WIDTH);
  assign total = (AW+1)'(h_eff) * (AW+1)'(w_eff);

  assign in_ready = (state == S_IDLE) && !busy_out;
  assign in_xfer = in_valid && in_ready;
  assign busy_out = out_valid && !out_ready;
  // a new result enters the output register this cycle
  assign out_load = (state == S_OUT) || (in_xfer && in_data.mode && !frame_ready);

  assign pix_wide = (COEF_W+9)'(in_data.pixel) << FRAC_BITS;
  assign wr_data = (pix_wide > (COEF_W+9)'(COEF_MAX)) ? COEF_W'(COEF_MAX) : COEF_W'(pix_wide);
  assign wr_addr = load_index[AW-1:0];
  assign rd_addr = read_index[AW-1:0];

  always_comb begin
    cmd = '0;
    cmd.wr_frame = in_xfer && !in_data.mode;
    cmd.pass_start = (state == S_ROWS) || (state == S_COLS);
    cmd.pass_col = (state == S_COLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      image_height <= CFG_W'(64);
      image_width <= CFG_W'(64);
      load_index <= '0;
      read_index <= '0;
      frame_ready <= 1'b0;
      out_valid <= 1'b0;
      pass_col <= 1'b0;
      rh <= '0;
      rw <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_W'(CFG_HEIGHT): begin
            image_height <= cfg_data;
            load_index <= '0; read_index <= '0; frame_ready <= 1'b0;
          end
          CFG_W'(CFG_WIDTH): begin
            image_width <= cfg_data;
            load_index <= '0; read_index <= '0; frame_ready <= 1'b0;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && !in_data.mode) begin
            if (frame_ready) begin
              frame_ready <= 1'b0;
              read_index <= '0;
            end
            if (((frame_ready ? '0 : load_index) + 1'b1) >= total) begin
              load_index <= '0;
              rh <= h_eff;
              rw <= w_eff;
              if (h_eff > DW'(1) || w_eff > DW'(1)) state <= S_ROWS;
              else frame_ready <= 1'b1;
            end else begin
              load_index <= (frame_ready ? '0 : load_index) + 1'b1;
            end
          end else if (in_xfer) begin
            if (!frame_ready) begin
              out_data <= '{coefficient: '0, last_coefficient: 1'b0, read_error: 1'b1};
              out_valid <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_ROWS: begin
          pass_col <= 1'b0;
          state <= S_WAIT;
        end
        S_COLS: begin
          pass_col <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (stat.pass_done) begin
            if (!pass_col) state <= S_COLS;
            else begin
              rh <= (rh + 1'b1) >> 1;
              rw <= (rw + 1'b1) >> 1;
              if (rh > DW'(2) || rw > DW'(2)) state <= S_ROWS;
              else begin
                frame_ready <= 1'b1;
                read_index <= '0;
                state <= S_IDLE;
              end
            end
          end
        end
        S_READ: state <= S_OUT;
        S_OUT: begin
          out_data <= '{coefficient: rd_data, last_coefficient: read_last, read_error: 1'b0};
          out_valid <= 1'b1;
          read_index <= read_last ? '0 : read_index + 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign read_last = (read_index + 1'b1) >= total;

`ifndef SYNTH
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input taken during transform or read");
  a_ready_after_levels: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && stat.pass_done && pass_col && rh <= DW'(2) && rw <= DW'(2))
    |=> frame_ready)
    else $error("frame not ready after last level");
  a_err_only_unready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid) && out_data.read_error) |-> !frame_ready)
    else $error("read error with frame ready");
`endif
endmodule

// ===== sv/haar_wavelet_2d_multilevel.sv =====
// Multi-level 2D Haar transform (averaging form) over one frame held in block memory.
// Load: one pixel per transfer; the last pixel starts the transform unless the frame is
// one pixel. Transform: each pass reads a pair and writes its average and difference, and
// copies an odd tail; reads are serial, set by the single memory read port of the pass
// engine. Readout: each coefficient is read from memory, registered, then output. Reset
// is synchronous and clears control state; the frame memories are undefined until loaded.
module haar_wavelet_2d_multilevel #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hw2d_pkg::CFG_W-1:0] cfg_index,
  input  logic [hw2d_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hw2d_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hw2d_pkg::out_item_t        out_data
);
  import hw2d_pkg::*;

  // address width covers the whole frame; dimension width holds the largest side itself
  localparam int AW = $clog2(MAX_HEIGHT * MAX_WIDTH);
  localparam int DW = $clog2((MAX_HEIGHT > MAX_WIDTH ? MAX_HEIGHT : MAX_WIDTH) + 1);

  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic signed [COEF_W-1:0] wr_data;
  logic signed [COEF_W-1:0] rd_data;
  logic [DW-1:0] w_eff;
  logic [DW-1:0] rh;
  logic [DW-1:0] rw;

  // controller: handshakes, indexes and level sequencing
  hw2d_ctrl #(
    .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH), .FRAC_BITS(FRAC_BITS),
    .AW(AW), .DW(DW)
  ) u_ctrl (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cmd, .stat, .wr_addr, .wr_data, .rd_addr, .rd_data, .w_eff, .rh, .rw
  );

  // datapath: memories and pass engine
  hw2d_datapath #(
    .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH), .AW(AW), .DW(DW)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .wr_addr, .wr_data, .rd_addr, .rd_data,
    .w_eff, .rh, .rw
  );
endmodule
